### design/time_of_day_alarm_slots_unit_macros.svh
// ----------------------------------------------------------------------------
// Alarm slot unit assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_ALARM_SLOTS_UNIT_MACROS_SVH
`define TIME_OF_DAY_ALARM_SLOTS_UNIT_MACROS_SVH

// Same-cycle implication.
`define TDAS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TDAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tdas_pkg.sv
// ----------------------------------------------------------------------------
// Alarm slot unit package
// Codes, limits, slot entry layout and time helper.
// ----------------------------------------------------------------------------
package tdas_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int MAX_RES       = 8;
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOUR_LAST     = 23;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ADD  = 1'b1;

    localparam logic [1:0] KIND_DAILY    = 2'd0;
    localparam logic [1:0] KIND_HOURLY   = 2'd1;
    localparam logic [1:0] KIND_REMINDER = 2'd2;
    localparam logic [1:0] KIND_INTERVAL = 2'd3;

    localparam logic [1:0] EV_FIRED = 2'd0;
    localparam logic [1:0] EV_ADDED = 2'd1;
    localparam logic [1:0] EV_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] alarm;     // {hour, minute}
        logic [9:0]  window;    // {first hour, last hour}
        logic [5:0]  interval;
        logic        done;
        logic        remove;
        logic [10:0] prev;      // {hour, minute}
    } slot_entry_t;

    function automatic logic [10:0] to_minutes(input logic [4:0] hour, input logic [5:0] minute);
        return 11'(hour) * 11'(MIN_PER_HOUR) + 11'(minute);
    endfunction

endpackage

### design/time_of_day_alarm_slots_unit.sv
// ----------------------------------------------------------------------------
// Time-of-day alarm slot unit
// Table of daily, hourly, reminder and interval alarm slots driven by ticks.
// ----------------------------------------------------------------------------
// An add item scans the slot memory for the first free slot, writes the new
// entry there and gives one result (a full result when no slot is free). A tick
// item with a known time walks the slot memory one slot per cycle, unless an
// output stall holds it, through its single write port and registered read
// port, then hands over the final fire result in a flush state.
// Output stalls lengthen both. A tick with unknown time gives no result.
// The input channel is stalled while an item is in work;
// one output register decouples the result side.
`include "time_of_day_alarm_slots_unit_macros.svh"

module time_of_day_alarm_slots_unit
    import tdas_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic       time_valid,
    input  logic [4:0] current_hour,
    input  logic [5:0] current_minute,
    input  logic [1:0] slot_kind,
    input  logic [4:0] alarm_hour,
    input  logic [5:0] alarm_minute,
    input  logic [4:0] first_hour,
    input  logic [4:0] last_hour,
    input  logic [5:0] interval_minutes,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] event_res,
    output logic [2:0] slot,
    output logic [1:0] fired_kind,
    output logic       last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_RES + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    // Sequencer state
    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] n_reg, n_next;

    // Captured item
    logic       tv_reg;
    logic [4:0] ch_reg, ah_reg, fh_reg, lh_reg;
    logic [5:0] cm_reg, am_reg, ivl_reg;
    logic [1:0] kind_reg;

    // Pending fire result, held until it is known whether another follows
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [1:0]       pend_kind_reg, pend_kind_next;

    // Output register
    logic       out_valid_reg;
    logic [1:0] ev_reg;
    logic [2:0] slot_reg;
    logic [1:0] kind_out_reg;
    logic       last_reg;
    logic       out_load;
    logic [1:0] ev_next;
    logic [2:0] slot_next;
    logic [1:0] kind_out_next;
    logic       last_next;
    logic       out_free;

    // Slot memory
    slot_entry_t mem [SLOTS];
    slot_entry_t rdata_reg;
    slot_entry_t wdata;
    logic        mem_we;

    // Shared time compare and per-slot evaluation
    logic [10:0] now_min, cmp_alarm;
    logic        ge;
    logic        in_win;
    logic [5:0]  pm;
    logic [7:0]  diff;
    logic        fire;
    slot_entry_t ent_upd, ent_add;
    logic        past;
    logic        slot_live;
    logic        report;
    logic        push;

    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Single compare unit: add checks the new alarm, the walk the stored one
    assign now_min   = to_minutes(ch_reg, cm_reg);
    assign cmp_alarm = (state_reg == S_SCAN) ? to_minutes(ah_reg, am_reg)
                                             : to_minutes(rdata_reg.alarm[10:6],
                                                          rdata_reg.alarm[5:0]);
    assign ge = (now_min >= cmp_alarm);

    assign in_win = (rdata_reg.window[9:5] <= ch_reg) && (ch_reg <= rdata_reg.window[4:0]);
    assign pm     = rdata_reg.prev[5:0];

    // New entry for an add
    always_comb
    begin
        past                 = tv_reg && ge;
        ent_add.kind         = kind_reg;
        ent_add.alarm        = {ah_reg, am_reg};
        ent_add.window       = {fh_reg, lh_reg};
        ent_add.interval     = ivl_reg;
        ent_add.done         = ((kind_reg == KIND_DAILY) || (kind_reg == KIND_REMINDER)) && past;
        ent_add.remove       = (kind_reg == KIND_REMINDER) && past;
        ent_add.prev         = tv_reg ? {ch_reg, cm_reg} : 11'd0;
    end

    // Tick update of the slot under the walk index
    always_comb
    begin
        ent_upd = rdata_reg;
        fire    = 1'b0;
        diff    = 8'd0;
        unique case (rdata_reg.kind)
            KIND_DAILY:
            begin
                fire = ge && !rdata_reg.done;
                if (fire)
                    ent_upd.done = 1'b1;
                // re-arm on the change from the last hour to midnight
                if ((rdata_reg.prev[10:6] == 5'(HOUR_LAST)) && (ch_reg == 5'd0))
                    ent_upd.done = 1'b0;
                ent_upd.prev = {ch_reg, cm_reg};
            end
            KIND_HOURLY:
            begin
                fire         = in_win && (rdata_reg.prev[10:6] != ch_reg);
                ent_upd.prev = {ch_reg, cm_reg};
            end
            KIND_REMINDER:
            begin
                fire = ge && !rdata_reg.done;
                if (fire)
                begin
                    ent_upd.done   = 1'b1;
                    ent_upd.remove = 1'b1;
                end
            end
            KIND_INTERVAL:
            begin
                // a previous minute past 60 can leave the wrapped gap negative
                if (cm_reg >= pm)
                    diff = {2'b00, cm_reg} - {2'b00, pm};
                else
                    diff = {2'b00, cm_reg} + 8'(MIN_PER_HOUR) - {2'b00, pm};
                fire = in_win && !diff[7] && (diff[6:0] >= {1'b0, rdata_reg.interval});
                if (fire)
                    ent_upd.prev = {ch_reg, cm_reg};
            end
            default:
            begin
                fire = 1'b0;
            end
        endcase
    end

    assign slot_live = valid_reg[idx_reg];
    assign report    = slot_live && fire && (n_reg < CNT_W'(MAX_RES));
    assign push      = report && pend_valid_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_kind_next  = pend_kind_reg;
        out_load        = 1'b0;
        ev_next         = EV_FIRED;
        slot_next       = 3'd0;
        kind_out_next   = 2'd0;
        last_next       = 1'b0;
        mem_we          = 1'b0;
        wdata           = ent_upd;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = '0;
                    if (func == FUNC_ADD)
                        state_next = S_SCAN;
                    else if (time_valid)
                    begin
                        state_next      = S_WALK;
                        n_next          = '0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                if (!valid_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        mem_we              = 1'b1;
                        wdata               = ent_add;
                        valid_next[idx_reg] = 1'b1;
                        out_load            = 1'b1;
                        ev_next             = EV_ADDED;
                        slot_next           = 3'(idx_reg);
                        kind_out_next       = kind_reg;
                        last_next           = 1'b1;
                        state_next          = S_IDLE;
                    end
                end
                else if (idx_reg == IDX_LAST)
                begin
                    if (out_free)
                    begin
                        out_load      = 1'b1;
                        ev_next       = EV_FULL;
                        slot_next     = 3'd0;
                        kind_out_next = kind_reg;
                        last_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            S_WALK:
            begin
                // hold the slot while an earlier fire cannot be handed over
                if (!push || out_free)
                begin
                    if (slot_live)
                    begin
                        mem_we = 1'b1;
                        if ((rdata_reg.kind == KIND_REMINDER) && ent_upd.remove)
                            valid_next[idx_reg] = 1'b0;
                    end
                    if (push)
                    begin
                        out_load      = 1'b1;
                        ev_next       = EV_FIRED;
                        slot_next     = 3'(pend_idx_reg);
                        kind_out_next = pend_kind_reg;
                        last_next     = 1'b0;
                    end
                    if (report)
                    begin
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                        pend_kind_next  = rdata_reg.kind;
                        n_next          = n_reg + CNT_W'(1);
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        idx_next   = '0;
                        state_next = S_FLUSH;
                    end
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    ev_next         = EV_FIRED;
                    slot_next       = 3'(pend_idx_reg);
                    kind_out_next   = pend_kind_reg;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            tv_reg   <= time_valid;
            ch_reg   <= current_hour;
            cm_reg   <= current_minute;
            kind_reg <= slot_kind;
            ah_reg   <= alarm_hour;
            am_reg   <= alarm_minute;
            fh_reg   <= first_hour;
            lh_reg   <= last_hour;
            ivl_reg  <= interval_minutes;
        end
        pend_idx_reg  <= pend_idx_next;
        pend_kind_reg <= pend_kind_next;
        if (out_load)
        begin
            ev_reg       <= ev_next;
            slot_reg     <= slot_next;
            kind_out_reg <= kind_out_next;
            last_reg     <= last_next;
        end
    end

    // Slot memory: one write port, registered read at the next walk index
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx_reg] <= wdata;
        rdata_reg <= mem[idx_next];
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = ev_reg;
    assign slot       = slot_reg;
    assign fired_kind = kind_out_reg;
    assign last       = last_reg;

    `TDAS_ASSERT_IMP(a_count_bound, 1'b1, n_reg <= CNT_W'(MAX_RES),
        "more fire results counted than allowed")
    `TDAS_ASSERT_IMP(a_pend_counted, pend_valid_reg, n_reg != '0,
        "pending fire result without a count")
    `TDAS_ASSERT_IMP(a_add_is_last, out_valid_reg && (ev_reg != EV_FIRED), last_reg,
        "add result without last flag")
    `TDAS_ASSERT_NEXT(a_add_scans, in_valid && !in_stall && (func == FUNC_ADD),
        state_reg == S_SCAN, "add item did not start a scan")

endmodule
